@@ rtl/stis_pkg.sv @@
// shared types and constants for the sorted table insert and search block
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package stis_pkg;

  localparam int OPCODE_W = 2;
  localparam int ITEM_W   = 16;
  localparam int STATUS_W = 3;
  localparam int HIT_W    = 4;
  localparam int PROBE_W  = 3;
  localparam int STORED_W = 5;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic                latch_item;
    logic                clear_cnt;
    logic                probe_rd;
    logic                probe_step;
    logic                shift_init;
    logic                shift_step;
    logic                inc_cnt;
    logic                load_out;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic hit;
    logic full;
    logic shift_done;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/sorted_table_insert_and_search.sv @@
// top level of the sorted table insert and search block
// instantiates stis_controller and stis_datapath, uses stis_pkg
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH unique values in ascending order in a simple dual-port
// style memory (one write, one registered read per cycle). Every insert or search
// request runs a binary search first, each probe a memory read, then a compare.
// An insert that misses, into a table that is not full, adds the shift: after the
// search it walks down from the top entry, moving one entry per cycle. Only one
// request is in progress at a time; the next request is taken as soon as the
// controller is idle, even while the previous result still waits in the output
// register.
module sorted_table_insert_and_search import stis_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // item_value[15:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // hit_index[3:0], probe_count[6:4], stored_count[11:7], zero
  output logic [2:0]  m_tuser    // status[2:0]
);

  cmd_t                cmd;
  sts_t                sts;
  logic [STATUS_W-1:0] out_status;
  logic [HIT_W-1:0]    out_hit;
  logic [PROBE_W-1:0]  out_probes;
  logic [STORED_W-1:0] out_stored;

  stis_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stis_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_value (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_hit    (out_hit),
    .out_probes (out_probes),
    .out_stored (out_stored)
  );

  assign m_tuser = out_status;
  assign m_tdata = {4'b0000, out_stored, out_probes, out_hit};

endmodule

@@ rtl/stis_datapath.sv @@
// datapath: table memory, search bounds, shift pointer, entry count, result register
// depends on stis_pkg
`timescale 1ns / 1ps

module stis_datapath import stis_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ITEM_W-1:0]   item_value,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HIT_W-1:0]    out_hit,
  output logic [PROBE_W-1:0]  out_probes,
  output logic [STORED_W-1:0] out_stored
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = AW + 1;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [AW-1:0]          mid;
  logic [AW-1:0]          mid_next;
  logic [MW-1:0]          misses;
  logic [AW-1:0]          pos;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_m1;
  logic [CW:0]            mid_sum;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   val_gt;

  assign val_in   = VALUE_WIDTH'(item_value);
  // hi is exclusive, so the inclusive upper bound is hi - 1
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
  assign mid_next = AW'(mid_sum >> 1);
  assign count_m1 = count - CW'(1);
  assign val_gt   = val > rdata;

  always_comb begin
    if (cmd.shift_init) begin
      rd_addr = count_m1[AW-1:0];
    end else if (cmd.shift_step) begin
      rd_addr = pos - AW'(2);
    end else begin
      rd_addr = mid_next;
    end
  end

  assign sts.range_empty = lo >= hi;
  assign sts.hit         = rdata == val;
  assign sts.full        = count == CW'(TABLE_DEPTH);
  assign sts.shift_done  = (pos == '0) || !(rdata > val);
  assign sts.out_busy    = out_valid && !out_ready;

  assign wr_en   = cmd.shift_step;
  assign wr_data = sts.shift_done ? val : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      val    <= val_in;
      lo     <= '0;
      hi     <= count;
      misses <= '0;
    end
    if (cmd.probe_rd) begin
      mid <= mid_next;
    end
    if (cmd.probe_step) begin
      misses <= misses + MW'(1);
      if (val_gt) begin
        lo <= CW'(mid) + CW'(1);
      end else begin
        hi <= CW'(mid);
      end
    end
    if (cmd.shift_init) begin
      pos <= count[AW-1:0];
    end else if (cmd.shift_step && !sts.shift_done) begin
      pos <= pos - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_cnt) begin
      count <= '0;
    end else if (cmd.inc_cnt) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.out_status;
      out_hit    <= (cmd.out_status == ST_FOUND) ? HIT_W'(mid) : '0;
      out_probes <= (cmd.out_status == ST_FOUND || cmd.out_status == ST_NOT_FOUND) ?
                    PROBE_W'(misses) : '0;
      out_stored <= STORED_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.inc_cnt |=> count == $past(count) + CW'(1))
    else $error("entry count did not advance after insert");

  a_shift_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step && !sts.shift_done |=> pos == $past(pos) - AW'(1))
    else $error("shift pointer did not step down");

endmodule

@@ rtl/stis_controller.sv @@
// controller: sequences binary search probes, the insertion shift and result hand-off
// depends on stis_pkg
`timescale 1ns / 1ps

module stis_controller import stis_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] opcode,
  output logic                in_ready,
  input  sts_t                sts,
  output cmd_t                cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [OPCODE_W-1:0] op;
  logic [OPCODE_W-1:0] op_next;
  logic [STATUS_W-1:0] res;
  logic [STATUS_W-1:0] res_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    res_next   = res;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          op_next        = opcode;
          case (opcode)
            OP_CLEAR: begin
              cmd.clear_cnt = 1'b1;
              res_next      = ST_CLEARED;
              state_next    = S_FIN;
            end
            OP_INSERT, OP_SEARCH: begin
              state_next = S_PROBE;
            end
            default: begin
              // unused opcode is dropped without a result
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (sts.range_empty) begin
          if (op == OP_SEARCH) begin
            res_next   = ST_NOT_FOUND;
            state_next = S_FIN;
          end else if (sts.full) begin
            res_next   = ST_FULL;
            state_next = S_FIN;
          end else begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          res_next   = (op == OP_SEARCH) ? ST_FOUND : ST_DUPLICATE;
          state_next = S_FIN;
        end else begin
          cmd.probe_step = 1'b1;
          state_next     = S_PROBE;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          cmd.inc_cnt = 1'b1;
          res_next    = ST_INSERTED;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.out_status = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op  <= op_next;
    res <= res_next;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over a pending result");

  a_shift_insert_only: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> op == OP_INSERT)
    else $error("shift entered for a non-insert request");

  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_FIN)
    else $error("controller state out of range");

endmodule

@@ bench/sorted_table_insert_and_search_tb.sv @@
// testbench for sorted_table_insert_and_search: directed and random requests with bursty
// input, a stalling output side and a scoreboard that predicts every result
// depends on stis_pkg and the sorted_table_insert_and_search rtl
`timescale 1ns / 1ps

module sorted_table_insert_and_search_tb;
  import stis_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1425;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {RX_READY, RX_RANDOM, RX_STALL} rx_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HIT_W-1:0]    hit;
    logic [PROBE_W-1:0]  probes;
    logic [STORED_W-1:0] stored;
  } table_result_t;

  class table_scoreboard;
    bit [ITEM_W-1:0] entries [DEPTH];
    int              count;
    table_result_t   awaited [$];
    int              errors;

    function int pending();
      return awaited.size();
    endfunction

    // updates the shadow table and queues the result the request must produce
    function void note_request(logic [OPCODE_W-1:0] op, logic [ITEM_W-1:0] value);
      table_result_t r;
      int            lo;
      int            hi;
      int            mid;
      int            pos;
      bit            dup;
      bit            hit;
      r = '0;
      case (op)
        OP_INSERT: begin
          dup = 1'b0;
          for (int i = 0; i < count; i++)
            if (entries[i] == value) dup = 1'b1;
          if (dup) begin
            r.status = ST_DUPLICATE;
          end else if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = count;
            while (pos > 0 && entries[pos-1] > value) begin
              entries[pos] = entries[pos-1];
              pos--;
            end
            entries[pos] = value;
            count++;
            r.status = ST_INSERTED;
          end
        end
        OP_SEARCH: begin
          lo  = 0;
          hi  = count - 1;
          hit = 1'b0;
          r.status = ST_NOT_FOUND;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (entries[mid] == value) begin
              hit      = 1'b1;
              r.status = ST_FOUND;
              r.hit    = HIT_W'(mid);
            end else begin
              if (value > entries[mid]) lo = mid + 1;
              else hi = mid - 1;
              r.probes++;
            end
          end
        end
        OP_CLEAR: begin
          count    = 0;
          r.status = ST_CLEARED;
        end
        default: return;  // unused opcode gives no result
      endcase
      r.stored = STORED_W'(count);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [15:0] tdata, logic [2:0] tuser);
      table_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d tdata %h", tuser, tdata);
        return;
      end
      want = awaited.pop_front();
      if (tuser !== want.status || tdata[3:0] !== want.hit || tdata[6:4] !== want.probes ||
          tdata[11:7] !== want.stored || tdata[15:12] !== 4'd0) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected status %0d hit %0d probes %0d stored %0d",
                   want.status, want.hit, want.probes, want.stored);
          $display("          got status %0d hit %0d probes %0d stored %0d pad %h",
                   tuser, tdata[3:0], tdata[6:4], tdata[11:7], tdata[15:12]);
        end
      end
    endfunction

    function void finish_check();
      if (awaited.size() != 0) begin
        errors++;
        $display("%0d results never arrived", awaited.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;

  table_scoreboard sb;
  int              idle_cycles = 0;
  int              items_sent  = 0;
  int              burst_left  = 0;
  bit              hold_req    = 1'b0;
  logic [15:0]     inserted_vals [$];

  sorted_table_insert_and_search #(
    .TABLE_DEPTH(16),
    .VALUE_WIDTH(16)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side: ready, coin-flip and stalled stretches, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    m_tready  = 1'b0;
    mode      = RX_READY;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = (mode == RX_STALL) ? $urandom_range(1, 15) : $urandom_range(1, 80);
        end
        mode_left--;
        case (mode)
          RX_READY:  m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= 1'b0;
        endcase
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] value);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    if (op != OP_UNUSED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
    end
  endtask

  // mix of wide random values, a narrow range for duplicates, extremes and stored neighbors
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom_range(0, 16'hffff));
      4, 5:       v = 16'($urandom_range(0, 31));
      6:          v = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: begin
        if (inserted_vals.size() == 0) v = 16'($urandom_range(0, 16'hffff));
        else v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)]
                 + 16'($urandom_range(0, 2)) - 16'd1 + 16'($urandom_range(0, 1));
      end
    endcase
    return v;
  endfunction

  initial begin
    int n_ins;
    int n_srch;
    logic [15:0] v;
    sb       = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_INSERT;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty search, extremes, duplicates, deepest shifts, full table, clear
    send_item(OP_SEARCH, 16'h0000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'hffff);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_SEARCH, 16'hffff);
    send_item(OP_SEARCH, 16'h1234);
    send_item(OP_UNUSED, 16'hffff);
    for (int i = 13; i >= 1; i--) send_item(OP_INSERT, 16'(i));
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_INSERT, 16'hffff);
    send_item(OP_SEARCH, 16'h0001);
    send_item(OP_SEARCH, 16'h8000);
    send_item(OP_CLEAR,  16'hffff);
    send_item(OP_SEARCH, 16'h0000);

    hold_req = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item(OP_CLEAR, 16'($urandom_range(0, 16'hffff)));
        inserted_vals.delete();
      end
      n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 12);
      repeat (n_ins) begin
        v = pick_value();
        send_item(OP_INSERT, v);
        inserted_vals.push_back(v);
      end
      n_srch = $urandom_range(2, 12);
      repeat (n_srch) begin
        v = pick_value();
        case ($urandom_range(0, 11))
          0:       send_item(OP_UNUSED, v);
          1, 2: begin
            send_item(OP_INSERT, v);
            inserted_vals.push_back(v);
          end
          default: send_item(OP_SEARCH, v);
        endcase
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/stis_pkg.sv
rtl/stis_datapath.sv
rtl/stis_controller.sv
rtl/sorted_table_insert_and_search.sv
bench/sorted_table_insert_and_search_tb.sv
